### hw/rtl/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared constants and types for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

    // Width of the converted value (4..64); input bits above it are ignored
    localparam int VALUE_BITS = 64;
    // Width of the input port, fixed by the interface
    localparam int IN_BITS    = 64;

    // Decimal digits of 2^VALUE_BITS - 1: floor(VALUE_BITS * log10(2)) + 1
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = 4 * NUM_DIGITS;

    // Counter widths
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    // Work queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ASCII code of '0', trimmed to the 6-bit character field
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### hw/rtl/binary_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Converts an unsigned binary value to decimal ASCII digits, MSB digit first.
// ----------------------------------------------------------------------------
// Each input transaction carries one value; the block answers with one output
// transaction per decimal digit, most significant first, leading zeros dropped
// (zero gives a single '0'), and last set on the final digit. In the converter a
// value is loaded, then runs through the shift-and-add-3 loop one bit at a time;
// the leading zeros are then skipped and the digits sent one by one, with a
// switch step between the skip and the output. The output stage stalls while
// the receiver holds off. A two-entry queue in front of the converter keeps
// taking input while a value is in work, and holds off the sender when full.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top
    import bda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [IN_BITS-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         digit_char,
    output logic               last
);

    q_status_t             q_status;
    logic                  q_push;
    logic                  q_pop;
    logic [VALUE_BITS-1:0] q_wdata;
    logic [VALUE_BITS-1:0] q_rdata;

    bda_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    bda_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .status    (q_status)
    );

    bda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule

### hw/rtl/bda_queue.sv
// ----------------------------------------------------------------------------
// bda_queue
// Short FIFO of masked values between the accepting front and the converter.
// ----------------------------------------------------------------------------
module bda_queue
    import bda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [VALUE_BITS-1:0] push_data,
    input  logic                  pop,
    output logic [VALUE_BITS-1:0] pop_data,
    output q_status_t             status
);

    logic [VALUE_BITS-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg;
    logic [QCNT_W-1:0]     count_next;

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

### hw/rtl/bda_front.sv
// ----------------------------------------------------------------------------
// bda_front
// Input side: accepts transactions, trims the value to VALUE_BITS, queues it.
// ----------------------------------------------------------------------------
module bda_front
    import bda_pkg::*;
(
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [IN_BITS-1:0]    value,
    input  q_status_t             q_status,
    output logic                  q_push,
    output logic [VALUE_BITS-1:0] q_data
);

    // Hold off the sender while the queue is full
    assign in_stall = q_status.full;
    assign q_push   = in_valid && !q_status.full;

    // Bits above VALUE_BITS take no part in the conversion
    assign q_data   = value[VALUE_BITS-1:0];

endmodule

### hw/rtl/bda_back.sv
// ----------------------------------------------------------------------------
// bda_back
// Converter: shift-and-add-3 to BCD, leading zero skip, digit-by-digit output.
// ----------------------------------------------------------------------------
module bda_back
    import bda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  q_status_t             q_status,
    input  logic [VALUE_BITS-1:0] q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [5:0]            digit_char,
    output logic                  last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [VALUE_BITS-1:0] shift_reg;
    logic [VALUE_BITS-1:0] shift_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [BIT_CNT_W-1:0]  bit_cnt_next;
    logic [DIG_CNT_W-1:0]  dig_left_reg;
    logic [DIG_CNT_W-1:0]  dig_left_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [5:0]            digit_reg;
    logic [5:0]            digit_next;
    logic                  last_reg;
    logic                  last_next;

    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_digit;
    logic                  out_free;
    logic                  emit_fire;
    logic                  final_digit;

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                bcd_reg[4*d +: 4] + 4'd3 : bcd_reg[4*d +: 4];
        end
    end

    assign top_digit   = bcd_reg[BCD_W-1 -: 4];
    assign out_free    = !out_valid_reg || !out_stall;
    assign emit_fire   = (state_reg == ST_EMIT) && out_free;
    assign final_digit = (dig_left_reg == DIG_CNT_W'(1));
    assign q_pop       = (state_reg == ST_IDLE) && !q_status.empty;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_left_next  = dig_left_reg;
        out_valid_next = out_valid_reg && out_stall;
        digit_next     = digit_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    shift_next   = q_data;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], shift_reg[VALUE_BITS-1]};
                shift_next   = {shift_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    dig_left_next = DIG_CNT_W'(NUM_DIGITS);
                    state_next    = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop one leading zero per cycle, always keep the last digit
                if (top_digit == 4'd0 && !final_digit)
                begin
                    bcd_next      = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_left_next = dig_left_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    digit_next     = ASCII_ZERO + {2'b00, top_digit};
                    last_next      = final_digit;
                    bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_left_next  = dig_left_reg - 1'b1;
                    if (final_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_left_reg <= dig_left_next;
        digit_reg    <= digit_next;
        last_reg     <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    // A digit being sent is always a valid BCD digit
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> top_digit <= 4'd9)
        else $error("bda_back: non-decimal digit in output phase");

    // Never run out of digits while emitting or skipping
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT || state_reg == ST_SKIP) |-> dig_left_reg != '0)
        else $error("bda_back: digit count underflow");

    // Sending the final digit returns the converter to idle with last set
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && final_digit) |=> (state_reg == ST_IDLE && out_valid_reg && last_reg))
        else $error("bda_back: final digit not closed correctly");

    // A new value is taken only when the converter is idle and data is queued
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE && !q_status.empty))
        else $error("bda_back: pop outside idle or from empty queue");
`endif

endmodule
